FILE: design/tiny_accumulator_cpu_step_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tiny accumulator CPU step unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TINY_ACCUMULATOR_CPU_STEP_UNIT_MACROS_SVH
`define TINY_ACCUMULATOR_CPU_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define TACS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TACS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tacs_pkg.sv
// ---------------------------------------------------------------------------
// tacs_pkg
// Types and constants of the tiny accumulator CPU step unit.
// ---------------------------------------------------------------------------
`default_nettype none

package tacs_pkg;

  localparam int HALF_MEMORY = 32;
  localparam int MEM_DEPTH   = 2 * HALF_MEMORY;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int OPND_W      = $clog2(HALF_MEMORY);

  localparam logic [7:0] CHAR_OFFSET = 8'd59;
  localparam logic [7:0] SPACE_CHAR  = 8'd32;

  localparam logic [OPND_W-1:0] INT_PRINT = OPND_W'(0);
  localparam logic [OPND_W-1:0] INT_HALT  = OPND_W'(1);

  typedef enum logic [1:0] {
    OPER_WRITE = 2'd0,
    OPER_EXEC  = 2'd1,
    OPER_LOAD  = 2'd2,
    OPER_NONE  = 2'd3
  } operation_e;

  typedef enum logic [2:0] {
    OPC_COPY  = 3'd0,
    OPC_READ  = 3'd1,
    OPC_WRITE = 3'd2,
    OPC_ADD   = 3'd3,
    OPC_SUB   = 3'd4,
    OPC_JUMP  = 3'd5,
    OPC_JZ    = 3'd6,
    OPC_INT   = 3'd7
  } opcode_e;

  typedef struct packed {
    operation_e        operation;
    logic [ADDR_W-1:0] mem_index;
    logic [7:0]        mem_value;
    logic [7:0]        new_pc;
    logic [7:0]        new_acc;
    logic              new_running;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pc_now;
    logic [7:0] acc_now;
    logic       running_now;
    logic       print_valid;
    logic [7:0] print_char;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

`default_nettype wire

FILE: design/tacs_mem.sv
// ---------------------------------------------------------------------------
// tacs_mem
// 64-byte store: program half plus two copies of the data half, so that
// instruction fetch and operand read each see a single-read array.
// ---------------------------------------------------------------------------
`default_nettype none

module tacs_mem (
  input  wire logic                          clk,
  input  wire tacs_pkg::mem_wr_t             wr,
  input  wire logic [tacs_pkg::ADDR_W-1:0]   fetch_addr,
  output logic [7:0]                         fetch_data,
  input  wire logic [tacs_pkg::OPND_W-1:0]   data_addr,
  output logic [7:0]                         data_rd
);

  logic [7:0] prog_mem  [tacs_pkg::HALF_MEMORY];
  logic [7:0] fdata_mem [tacs_pkg::HALF_MEMORY];
  logic [7:0] data_mem  [tacs_pkg::HALF_MEMORY];

  logic                        wr_hi;
  logic [tacs_pkg::OPND_W-1:0] wr_row;
  logic                        fetch_hi;
  logic [tacs_pkg::OPND_W-1:0] fetch_row;

  assign wr_hi     = wr.addr[tacs_pkg::ADDR_W-1];
  assign wr_row    = wr.addr[tacs_pkg::OPND_W-1:0];
  assign fetch_hi  = fetch_addr[tacs_pkg::ADDR_W-1];
  assign fetch_row = fetch_addr[tacs_pkg::OPND_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr_hi) begin
        fdata_mem[wr_row] <= wr.data;
        data_mem[wr_row]  <= wr.data;
      end else begin
        prog_mem[wr_row] <= wr.data;
      end
    end
  end

  assign fetch_data = fetch_hi ? fdata_mem[fetch_row] : prog_mem[fetch_row];
  assign data_rd    = data_mem[data_addr];

endmodule

`default_nettype wire

FILE: design/tiny_accumulator_cpu_step_unit.sv
// ---------------------------------------------------------------------------
// tiny_accumulator_cpu_step_unit
// 8-bit accumulator CPU with a 64-byte memory, one transaction per step.
// ---------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one transaction: a
//   memory byte write, one instruction execute, or a context load.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   command: pc, accumulator and run state after it, plus any display char.
//   Latency: the result is valid the cycle after the command is accepted.
//   Throughput: one command per cycle while cmd_stall is low. Fetch,
//   operand read, ALU and next-pc selection all sit in one combinational
//   pass from the state registers and the store to the result register.
//   The result register acts as the skid stage: a new command is taken
//   while a result is held unless rsp_stall is high with rsp_valid set,
//   in which case cmd_stall is raised.
//   Reset: pc and accumulator clear to zero, the CPU is running, no result
//   is pending. Memory content is not cleared and is undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tiny_accumulator_cpu_step_unit_macros.svh"

module tiny_accumulator_cpu_step_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire tacs_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output tacs_pkg::rsp_t      rsp
);

  logic [7:0] pc;
  logic [7:0] acc;
  logic       running;

  logic [7:0] pc_next;
  logic [7:0] acc_next;
  logic       running_next;
  logic       print_valid;
  logic [7:0] print_char;

  logic                        accept;
  tacs_pkg::mem_wr_t           mem_wr;
  logic [7:0]                  instr;
  tacs_pkg::opcode_e           opcode;
  logic [tacs_pkg::OPND_W-1:0] operand;
  logic [tacs_pkg::OPND_W-1:0] rd_addr;
  logic [7:0]                  rd_data;
  logic [7:0]                  pc_inc;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  tacs_mem u_mem (
    .clk        (clk),
    .wr         (mem_wr),
    .fetch_addr (pc[tacs_pkg::ADDR_W-1:0]),
    .fetch_data (instr),
    .data_addr  (rd_addr),
    .data_rd    (rd_data)
  );

  assign opcode  = tacs_pkg::opcode_e'(instr[7:5]);
  assign operand = instr[tacs_pkg::OPND_W-1:0];
  assign rd_addr = (opcode == tacs_pkg::OPC_INT) ? acc[tacs_pkg::OPND_W-1:0] : operand;
  assign pc_inc  = pc + 8'd1;

  always_comb begin
    pc_next      = pc;
    acc_next     = acc;
    running_next = running;
    print_valid  = 1'b0;
    print_char   = 8'd0;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = cmd.mem_index;
    mem_wr.data  = cmd.mem_value;

    unique case (cmd.operation)
      tacs_pkg::OPER_WRITE: begin
        mem_wr.en = accept;
      end
      tacs_pkg::OPER_EXEC: begin
        if (running) begin
          pc_next = pc_inc;
          unique case (opcode)
            tacs_pkg::OPC_COPY: acc_next = 8'(operand);
            tacs_pkg::OPC_READ: acc_next = rd_data;
            tacs_pkg::OPC_WRITE: begin
              mem_wr.en   = accept;
              mem_wr.addr = {1'b1, operand};
              mem_wr.data = acc;
            end
            tacs_pkg::OPC_ADD: acc_next = acc + rd_data;
            tacs_pkg::OPC_SUB: acc_next = acc - rd_data;
            tacs_pkg::OPC_JUMP: begin
              pc_next  = acc;
              acc_next = 8'(operand);
            end
            tacs_pkg::OPC_JZ: begin
              if (acc == 8'd0) pc_next = 8'(operand);
            end
            tacs_pkg::OPC_INT: begin
              if (operand == tacs_pkg::INT_PRINT) begin
                print_valid = 1'b1;
                print_char  = (rd_data != 8'd0) ? tacs_pkg::CHAR_OFFSET + rd_data
                                                : tacs_pkg::SPACE_CHAR;
              end
              if (operand == tacs_pkg::INT_HALT) running_next = 1'b0;
            end
          endcase
        end
      end
      tacs_pkg::OPER_LOAD: begin
        pc_next      = cmd.new_pc;
        acc_next     = cmd.new_acc;
        running_next = cmd.new_running;
      end
      tacs_pkg::OPER_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 8'd0;
      acc       <= 8'd0;
      running   <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        pc        <= pc_next;
        acc       <= acc_next;
        running   <= running_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.pc_now      <= pc_next;
      rsp.acc_now     <= acc_next;
      rsp.running_now <= running_next;
      rsp.print_valid <= print_valid;
      rsp.print_char  <= print_char;
    end
  end

  `TACS_ASSERT_NOW(a_held_blocks, clk, rst, rsp_valid && rsp_stall, cmd_stall, "held result not protected")
  `TACS_ASSERT_NEXT(a_accept_valid, clk, rst, accept, rsp_valid, "accepted command gave no result")
  `TACS_ASSERT_NEXT(a_rsp_state, clk, rst, accept, (rsp.pc_now == pc) && (rsp.acc_now == acc) && (rsp.running_now == running), "result differs from state")
  `TACS_ASSERT_NOW(a_no_char, clk, rst, rsp_valid && !rsp.print_valid, rsp.print_char == 8'd0, "char without print")
  `TACS_ASSERT_NEXT(a_halted_exec, clk, rst, accept && (cmd.operation == tacs_pkg::OPER_EXEC) && !running, (pc == $past(pc)) && (acc == $past(acc)) && !running, "halted step changed state")

endmodule

`default_nettype wire
